@@ design/pcg32_pkg.sv @@
// Shared types and constants for the PCG32 XSH-RR generator.
// Used by the configuration interface, the top level and the testbench; depends on nothing.
package pcg32_pkg;

  localparam logic [63:0] LcgMult  = 64'h5851_F42D_4C95_7F2D;
  localparam logic [63:0] LcgReset = 64'h5851_F42D_4C95_7F2E;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned UnitShift = 11;

  typedef enum logic [2:0] {
    CMD_DRAW32  = 3'd0,
    CMD_BOUNDED = 3'd1,
    CMD_DRAW64  = 3'd2,
    CMD_UNIT    = 3'd3,
    CMD_RESEED  = 3'd4
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SEED   = 1'b0,
    CFG_STREAM = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RESEED,
    S_DRAW,
    S_DIV,
    S_DONE
  } state_e;

  // Output permutation of PCG32: xorshift high bits, then rotate right.
  function automatic logic [31:0] pcg_permute(input logic [63:0] old);
    logic [63:0] mixed;
    logic [31:0] xs;
    logic [4:0]  rot;
    logic [63:0] twice;
    mixed = (old >> 18) ^ old;
    xs    = mixed[58:27];
    rot   = old[63:59];
    twice = {xs, xs} >> rot;
    return twice[31:0];
  endfunction

endpackage

@@ design/pcg32_in_if.sv @@
// Input channel of the PCG32 generator: one command item per handshake.
// Stand-alone interface; it does not depend on pcg32_pkg.
interface pcg32_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic signed [31:0] lower_limit;
  logic signed [31:0] upper_bound_excl;

  modport source (output valid, cmd, lower_limit, upper_bound_excl, input ready);
  modport sink   (input valid, cmd, lower_limit, upper_bound_excl, output ready);
endinterface

@@ design/pcg32_out_if.sv @@
// Result channel of the PCG32 generator: one result item per handshake.
// Stand-alone interface with no dependencies.
interface pcg32_out_if;
  logic               valid;
  logic               ready;
  logic [63:0]        random_bits;
  logic signed [31:0] bounded_value;

  modport source (output valid, random_bits, bounded_value, input ready);
  modport sink   (input valid, random_bits, bounded_value, output ready);
endinterface

@@ design/pcg32_cfg_if.sv @@
// Configuration write channel of the PCG32 generator.
// Uses the register index width from pcg32_pkg.
interface pcg32_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [pcg32_pkg::CfgIdxW-1:0]         index;
  logic [63:0]                           data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/pcg32_random_generator.sv @@
// PCG32 XSH-RR generator top level with its sequencer and shared datapath.
// Depends on pcg32_pkg and the three channel interfaces.
//
// One item is worked on at a time and the input is ready only while the block is idle;
// a finished result sits in an output register, so the next item is taken while it
// waits. Every draw goes through one shared 32x32 multiplier in three partial products,
// one accumulate and one increment add. Command 0 makes one draw, command 4 a reseed
// step and one draw, commands 2 and 3 two draws each; unused commands go straight to the
// result. A bounded integer runs a bit-serial remainder for the threshold, draws until
// a draw is not below it and runs a second bit-serial remainder on that draw;
// an empty range answers without either.
module pcg32_random_generator
  import pcg32_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  pcg32_cfg_if.sink   cfg_i,
  pcg32_in_if.sink    in_i,
  pcg32_out_if.source out_o
);

  state_e       state_q, state_d;
  logic [2:0]   mstep_q, mstep_d;
  logic [4:0]   div_cnt_q, div_cnt_d;
  logic         second_q, second_d;
  logic         phase_q, phase_d;
  logic [63:0]  lcg_q, lcg_d;
  logic [63:0]  inc_q, inc_d;
  logic [63:0]  seed_q, seed_d;
  logic [62:0]  stream_q, stream_d;
  logic         out_valid_q, out_valid_d;

  logic [2:0]   cmd_q, cmd_d;
  logic [31:0]  lower_q, lower_d;
  logic [31:0]  range_q, range_d;
  logic [31:0]  thr_q, thr_d;
  logic [31:0]  dvd_q, dvd_d;
  logic [31:0]  rem_q, rem_d;
  logic [31:0]  draw_q, draw_d;
  logic [31:0]  hi_q, hi_d;
  logic [63:0]  prod_q, prod_d;
  logic [63:0]  acc_q, acc_d;
  logic [63:0]  res_bits_q, res_bits_d;
  logic [31:0]  res_bval_q, res_bval_d;
  logic [63:0]  out_bits_q, out_bits_d;
  logic [31:0]  out_bval_q, out_bval_d;

  logic [31:0]  mul_a, mul_b;
  logic [63:0]  mul_p;
  logic [32:0]  div_trial;
  logic [32:0]  div_diff;
  logic [31:0]  rem_next;
  logic [63:0]  both_draws;

  assign mul_a = (mstep_q == 3'd1) ? lcg_q[63:32] : lcg_q[31:0];
  assign mul_b = (mstep_q == 3'd2) ? LcgMult[63:32] : LcgMult[31:0];
  assign mul_p = mul_a * mul_b;

  assign div_trial = {rem_q, dvd_q[31]};
  assign div_diff  = div_trial - {1'b0, range_q};
  assign rem_next  = div_diff[32] ? div_trial[31:0] : div_diff[31:0];

  assign both_draws = {hi_q, draw_q};

  assign cfg_i.ready       = 1'b1;
  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.random_bits = out_bits_q;
  assign out_o.bounded_value = out_bval_q;

  always_comb begin
    state_d     = state_q;
    mstep_d     = mstep_q;
    div_cnt_d   = div_cnt_q;
    second_d    = second_q;
    phase_d     = phase_q;
    lcg_d       = lcg_q;
    inc_d       = inc_q;
    seed_d      = seed_q;
    stream_d    = stream_q;
    out_valid_d = out_valid_q && !out_o.ready;
    cmd_d       = cmd_q;
    lower_d     = lower_q;
    range_d     = range_q;
    thr_d       = thr_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    draw_d      = draw_q;
    hi_d        = hi_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    res_bits_d  = res_bits_q;
    res_bval_d  = res_bval_q;
    out_bits_d  = out_bits_q;
    out_bval_d  = out_bval_q;

    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_SEED:   seed_d = cfg_i.data;
        CFG_STREAM: stream_d = cfg_i.data[62:0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          cmd_d      = in_i.cmd;
          lower_d    = in_i.lower_limit;
          range_d    = in_i.upper_bound_excl - in_i.lower_limit;
          res_bits_d = '0;
          res_bval_d = '0;
          mstep_d    = '0;
          second_d   = 1'b0;
          case (in_i.cmd)
            CMD_DRAW32, CMD_DRAW64, CMD_UNIT: state_d = S_DRAW;
            CMD_BOUNDED: begin
              if (in_i.upper_bound_excl <= in_i.lower_limit) begin
                res_bval_d = in_i.lower_limit;
                state_d    = S_DONE;
              end else begin
                dvd_d     = 32'd0 - (in_i.upper_bound_excl - in_i.lower_limit);
                rem_d     = '0;
                div_cnt_d = '0;
                phase_d   = 1'b0;
                state_d   = S_DIV;
              end
            end
            CMD_RESEED: state_d = S_RESEED;
            default:    state_d = S_DONE;
          endcase
        end
      end
      S_RESEED: begin
        // Clearing the state and drawing once leaves exactly the increment.
        inc_d   = {stream_q, 1'b1};
        lcg_d   = {stream_q, 1'b1} + seed_q;
        mstep_d = '0;
        state_d = S_DRAW;
      end
      S_DRAW: begin
        mstep_d = mstep_q + 3'd1;
        case (mstep_q)
          3'd0: begin
            draw_d = pcg_permute(lcg_q);
            prod_d = mul_p;
          end
          3'd1: begin
            acc_d  = prod_q;
            prod_d = mul_p;
          end
          3'd2: begin
            acc_d  = {acc_q[63:32] + prod_q[31:0], acc_q[31:0]};
            prod_d = mul_p;
          end
          3'd3: begin
            acc_d = {acc_q[63:32] + prod_q[31:0], acc_q[31:0]};
          end
          default: begin
            lcg_d   = acc_q + inc_q;
            mstep_d = '0;
            case (cmd_q)
              CMD_DRAW32: begin
                res_bits_d = {32'd0, draw_q};
                state_d    = S_DONE;
              end
              CMD_BOUNDED: begin
                if (draw_q >= thr_q) begin
                  dvd_d     = draw_q;
                  rem_d     = '0;
                  div_cnt_d = '0;
                  phase_d   = 1'b1;
                  state_d   = S_DIV;
                end
              end
              CMD_DRAW64, CMD_UNIT: begin
                if (!second_q) begin
                  hi_d     = draw_q;
                  second_d = 1'b1;
                end else if (cmd_q == CMD_UNIT) begin
                  res_bits_d = both_draws >> UnitShift;
                  state_d    = S_DONE;
                end else begin
                  res_bits_d = both_draws;
                  state_d    = S_DONE;
                end
              end
              default: state_d = S_DONE;
            endcase
          end
        endcase
      end
      S_DIV: begin
        rem_d     = rem_next;
        dvd_d     = {dvd_q[30:0], 1'b0};
        div_cnt_d = div_cnt_q + 5'd1;
        if (div_cnt_q == 5'd31) begin
          if (!phase_q) begin
            thr_d   = rem_next;
            mstep_d = '0;
            state_d = S_DRAW;
          end else begin
            res_bval_d = lower_q + rem_next;
            state_d    = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_bits_d  = res_bits_q;
          out_bval_d  = res_bval_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mstep_q     <= '0;
      div_cnt_q   <= '0;
      second_q    <= 1'b0;
      phase_q     <= 1'b0;
      lcg_q       <= LcgReset;
      inc_q       <= 64'd1;
      seed_q      <= '0;
      stream_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mstep_q     <= mstep_d;
      div_cnt_q   <= div_cnt_d;
      second_q    <= second_d;
      phase_q     <= phase_d;
      lcg_q       <= lcg_d;
      inc_q       <= inc_d;
      seed_q      <= seed_d;
      stream_q    <= stream_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    lower_q    <= lower_d;
    range_q    <= range_d;
    thr_q      <= thr_d;
    dvd_q      <= dvd_d;
    rem_q      <= rem_d;
    draw_q     <= draw_d;
    hi_q       <= hi_d;
    prod_q     <= prod_d;
    acc_q      <= acc_d;
    res_bits_q <= res_bits_d;
    res_bval_q <= res_bval_d;
    out_bits_q <= out_bits_d;
    out_bval_q <= out_bval_d;
  end

  // An accepted item always starts work, so the input drops ready.
  a_accept_leaves_idle: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> state_q != S_IDLE
  ) else $error("accepted item did not start work");

  // A result leaving the sequencer lands in the output register.
  a_done_loads_output: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && (!out_valid_q || out_o.ready) |=> out_valid_q && state_q == S_IDLE
  ) else $error("finished result was not registered");

  // The partial remainder stays below the range throughout the division.
  a_rem_below_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> rem_q < range_q
  ) else $error("remainder reached the range");

  // The multiply sequence never runs past its last step.
  a_mstep_bound: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DRAW |-> mstep_q <= 3'd4
  ) else $error("draw step counter out of range");

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the PCG32 XSH-RR generator top level.
// Drives random and directed command items, predicts each result in place and
// compares it. Needs pcg32_pkg and the cfg, input and result channel interfaces.
module tb
  import pcg32_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Period     = 10;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned HoldCycles = 400;

  typedef struct {
    logic [2:0]         cmd;
    logic signed [31:0] lower;
    logic signed [31:0] upper;
  } gen_cmd_t;

  typedef struct {
    logic [63:0] bits;
    logic [31:0] bval;
  } gen_result_t;

  typedef struct {
    cfg_idx_e    idx;
    logic [63:0] data;
  } reg_write_t;

  logic clk_i;
  logic rst_ni;

  pcg32_cfg_if cfg_if ();
  pcg32_in_if  in_if ();
  pcg32_out_if out_if ();

  pcg32_random_generator u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  gen_cmd_t    cmd_backlog[$];
  reg_write_t  reg_writes[$];
  gen_result_t pending_results[$];

  logic [63:0] gen_state;
  logic [63:0] gen_inc;
  logic [63:0] seed_reg;
  logic [62:0] stream_reg;

  int unsigned tx_gap_pct;
  int unsigned rx_stall_pct;
  logic        hold_armed;
  logic        hold_used;
  int unsigned hold_left;
  int unsigned fault_count;
  int unsigned quiet_cycles;

  always #(Period / 2) clk_i = ~clk_i;

  function automatic logic [31:0] next_word();
    logic [63:0] prev;
    logic [31:0] xs;
    logic [5:0]  rot;
    prev      = gen_state;
    gen_state = prev * LcgMult + gen_inc;
    xs        = 32'(((prev >> 18) ^ prev) >> 27);
    rot       = {1'b0, prev[63:59]};
    return (xs >> rot) | (xs << ((6'd32 - rot) & 6'd31));
  endfunction

  function automatic void reseed_gen(input logic [63:0] seed, input logic [62:0] stream);
    gen_state = '0;
    gen_inc   = {stream, 1'b1};
    void'(next_word());
    gen_state = gen_state + seed;
    void'(next_word());
  endfunction

  function automatic logic [31:0] bounded_pick(input logic signed [31:0] lo,
                                               input logic signed [31:0] hi);
    logic [31:0] span;
    logic [31:0] threshold;
    logic [31:0] word;
    if (hi <= lo) begin
      return lo;
    end
    span      = 32'(hi - lo);
    threshold = (32'd0 - span) % span;
    do begin
      word = next_word();
    end while (word < threshold);
    return 32'(lo) + (word % span);
  endfunction

  function automatic gen_result_t predict_result(input gen_cmd_t c);
    gen_result_t r;
    logic [63:0] pair;
    r.bits = '0;
    r.bval = '0;
    case (c.cmd)
      CMD_DRAW32: begin
        r.bits = {32'd0, next_word()};
      end
      CMD_BOUNDED: begin
        r.bval = bounded_pick(c.lower, c.upper);
      end
      CMD_DRAW64, CMD_UNIT: begin
        pair[63:32] = next_word();
        pair[31:0]  = next_word();
        r.bits = (c.cmd == CMD_UNIT) ? (pair >> UnitShift) : pair;
      end
      CMD_RESEED: begin
        reseed_gen(seed_reg, stream_reg);
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic gen_cmd_t rand_item();
    gen_cmd_t    c;
    int unsigned pick;
    longint      lo_l;
    longint      hi_l;
    c.lower = $urandom;
    c.upper = $urandom;
    pick = $urandom_range(99);
    if (pick < 20) c.cmd = CMD_DRAW32;
    else if (pick < 55) c.cmd = CMD_BOUNDED;
    else if (pick < 70) c.cmd = CMD_DRAW64;
    else if (pick < 82) c.cmd = CMD_UNIT;
    else if (pick < 92) c.cmd = CMD_RESEED;
    else c.cmd = 3'($urandom_range(7, 5));
    if (c.cmd == CMD_BOUNDED) begin
      lo_l = -64'sd2147483648 + longint'($urandom_range(1 << 20));
      case ($urandom_range(4))
        1: begin
          c.upper = c.lower + 32'($urandom_range(64, 1));
        end
        2: begin
          hi_l = lo_l + (64'sd1 << $urandom_range(31));
          if (hi_l > 64'sd2147483647) hi_l = 64'sd2147483647;
          c.lower = 32'(lo_l);
          c.upper = 32'(hi_l);
        end
        3: begin
          hi_l = lo_l + 64'sd2147483648 + longint'($urandom_range(32'h7FFF_FFFF, 1));
          if (hi_l > 64'sd2147483647) hi_l = 64'sd2147483647;
          c.lower = 32'(lo_l);
          c.upper = 32'(hi_l);
        end
        4: begin
          c.upper = c.lower - 32'($urandom_range(3));
        end
        default: begin
        end
      endcase
    end
    return c;
  endfunction

  task automatic push_item(input logic [2:0] cmd, input logic signed [31:0] lo,
                           input logic signed [31:0] hi);
    gen_cmd_t c;
    c.cmd   = cmd;
    c.lower = lo;
    c.upper = hi;
    cmd_backlog.insert(cmd_backlog.size(), c);
  endtask

  task automatic drain();
    while (cmd_backlog.size() != 0 || in_if.valid || reg_writes.size() != 0 ||
           cfg_if.valid || pending_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_regs(input logic [63:0] seed, input logic [63:0] stream);
    reg_write_t w;
    drain();
    w.idx  = CFG_SEED;
    w.data = seed;
    reg_writes.insert(reg_writes.size(), w);
    w.idx  = CFG_STREAM;
    w.data = stream;
    reg_writes.insert(reg_writes.size(), w);
    drain();
  endtask

  task automatic random_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                              input int unsigned count);
    drain();
    tx_gap_pct   = tx_pct;
    rx_stall_pct = rx_pct;
    push_item(CMD_RESEED, '0, '0);
    for (int unsigned k = 1; k < count; k++) begin
      cmd_backlog.insert(cmd_backlog.size(), rand_item());
    end
  endtask

  // Command driver; the expected result of each accepted item is computed here.
  always @(posedge clk_i or negedge rst_ni) begin
    gen_cmd_t c;
    if (!rst_ni) begin
      in_if.valid            <= 1'b0;
      in_if.cmd              <= CMD_DRAW32;
      in_if.lower_limit      <= '0;
      in_if.upper_bound_excl <= '0;
      reseed_gen(64'd0, 63'd0);
      pending_results.delete();
    end else begin
      if (in_if.valid && in_if.ready) begin
        c.cmd   = in_if.cmd;
        c.lower = in_if.lower_limit;
        c.upper = in_if.upper_bound_excl;
        pending_results.insert(pending_results.size(), predict_result(c));
      end
      if (!in_if.valid || in_if.ready) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= tx_gap_pct) begin
          c = cmd_backlog.pop_front();
          in_if.valid            <= 1'b1;
          in_if.cmd              <= c.cmd;
          in_if.lower_limit      <= c.lower;
          in_if.upper_bound_excl <= c.upper;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    reg_write_t w;
    if (!rst_ni) begin
      cfg_if.valid <= 1'b0;
      cfg_if.index <= CFG_SEED;
      cfg_if.data  <= '0;
      seed_reg     <= '0;
      stream_reg   <= '0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.index == CFG_SEED) begin
          seed_reg <= cfg_if.data;
        end else begin
          stream_reg <= cfg_if.data[62:0];
        end
      end
      if (!cfg_if.valid || cfg_if.ready) begin
        if (reg_writes.size() != 0) begin
          w = reg_writes.pop_front();
          cfg_if.valid <= 1'b1;
          cfg_if.index <= w.idx;
          cfg_if.data  <= w.data;
        end else begin
          cfg_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_armed && !hold_used) begin
      hold_left <= HoldCycles;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor.
  always @(posedge clk_i or negedge rst_ni) begin
    gen_result_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      fault_count  <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          if (fault_count < 10) begin
            $display("%0t: result with none expected: bits=%h bounded=%h", $realtime,
                     out_if.random_bits, out_if.bounded_value);
          end
          fault_count <= fault_count + 1;
        end else begin
          want = pending_results.pop_front();
          if (out_if.random_bits !== want.bits || out_if.bounded_value !== want.bval) begin
            if (fault_count < 10) begin
              $display("%0t: mismatch: bits exp %h got %h, bounded exp %h got %h",
                       $realtime, want.bits, out_if.random_bits, want.bval,
                       out_if.bounded_value);
            end
            fault_count <= fault_count + 1;
          end
        end
      end
      out_if.ready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
        $display("tb: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    clk_i                  = 1'b0;
    rst_ni                 = 1'b0;
    tx_gap_pct             = 0;
    rx_stall_pct           = 0;
    hold_armed             = 1'b0;
    quiet_cycles           = 0;
    in_if.valid            = 1'b0;
    in_if.cmd              = CMD_DRAW32;
    in_if.lower_limit      = '0;
    in_if.upper_bound_excl = '0;
    cfg_if.valid           = 1'b0;
    cfg_if.index           = CFG_SEED;
    cfg_if.data            = '0;
    out_if.ready           = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    push_item(CMD_DRAW32, '0, '0);
    push_item(CMD_DRAW64, '0, '0);
    push_item(CMD_UNIT, '0, '0);
    push_item(3'd5, 32'sh7FFF_FFFF, -32'sd1);
    push_item(3'd6, '0, '0);
    push_item(3'd7, -32'sd1, 32'sh8000_0000);
    push_item(CMD_BOUNDED, 32'sh8000_0000, 32'sh7FFF_FFFF);
    push_item(CMD_BOUNDED, 32'sd0, 32'sd1);
    push_item(CMD_BOUNDED, 32'sd5, 32'sd5);
    push_item(CMD_BOUNDED, 32'sd7, -32'sd3);
    push_item(CMD_BOUNDED, 32'sh7FFF_FFFF, 32'sh8000_0000);
    push_item(CMD_BOUNDED, 32'sh8000_0000, 32'sd1);
    push_item(CMD_BOUNDED, 32'sh8000_0000, 32'sh8000_0003);
    push_item(CMD_BOUNDED, -32'sd1, 32'sd0);
    push_item(CMD_RESEED, '0, '0);
    push_item(CMD_DRAW32, '0, '0);

    set_regs(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    push_item(CMD_DRAW32, '0, '0);
    push_item(CMD_RESEED, '0, '0);
    push_item(CMD_DRAW32, '0, '0);
    push_item(CMD_DRAW64, '0, '0);
    push_item(CMD_UNIT, '0, '0);
    push_item(CMD_BOUNDED, -32'sd100, 32'sd100);

    set_regs({$urandom, $urandom}, {$urandom, $urandom});
    random_phase(0, 0, 280);
    set_regs(64'd0, 64'h7FFF_FFFF_FFFF_FFFF);
    random_phase(81, 0, 270);
    set_regs(64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
    random_phase(0, 81, 270);
    set_regs({$urandom, $urandom}, {$urandom, $urandom});
    random_phase(26, 26, 280);
    set_regs({$urandom, $urandom}, 64'd1);
    random_phase(0, 0, 270);
    hold_armed = 1'b1;
    set_regs({$urandom, $urandom}, {$urandom, $urandom});
    random_phase(40, 40, 280);

    drain();
    repeat (100) @(negedge clk_i);
    if (fault_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
